// ===== rtl/core/skng_pkg.sv =====
// Shared types, constants and arithmetic helpers of the soft-knee noise gate.
package skng_pkg;

    localparam int CHANNELS_DEF    = 2;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int WIDE_W = 68;
    localparam int RED_W  = 18;
    localparam int DIV_W  = 34;
    localparam int CNT_W  = 6;

    localparam int SQ_STEPS   = 16;
    localparam int DIV_STEPS  = 34;
    localparam int GAIN_STEPS = 16;

    localparam logic signed [RED_W-1:0] DB_FLOOR  = -18'sd25600;
    localparam logic signed [RED_W-1:0] RED_FLOOR = -18'sd65280;

    localparam logic signed [MUL_W-1:0] DB_PER_OCT_Q16 = 33'sd394566;
    localparam logic signed [MUL_W-1:0] OCT_PER_DB_Q24 = 33'sd2786635;
    localparam logic signed [MUL_W-1:0] UNITY_Q30      = 33'sd1073741824;
    localparam logic [16:0]             MIX_FULL       = 17'h10000;

    localparam logic signed [15:0] THRESHOLD_RST = -16'sd10240;
    localparam logic [13:0]        KNEE_RST      = 14'd0;
    localparam logic [14:0]        SLOPE_RST     = 15'd256;
    localparam logic [15:0]        ATTACK_RST    = 16'd65400;
    localparam logic [15:0]        RELEASE_RST   = 16'd65400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_KNEE      = 3'd1,
        REG_SLOPE     = 3'd2,
        REG_ATTACK    = 3'd3,
        REG_RELEASE   = 3'd4,
        REG_MIX       = 3'd5,
        REG_USE_KEY   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] threshold;
        logic [13:0]        knee;
        logic [14:0]        slope;
        logic [15:0]        attack;
        logic [15:0]        release_c;
        logic [16:0]        mix;
        logic               use_key;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_NORM, OP_SQ_MUL, OP_SQ_POST, OP_LG_MUL, OP_DB,
        OP_GC_MUL, OP_KNEE_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_TGT, OP_SM_MUL,
        OP_SM, OP_GL_MUL, OP_GL, OP_GM_MUL, OP_GM_POST, OP_GSHIFT, OP_WET_MUL,
        OP_WET, OP_MIX_MUL1, OP_MIX_MUL2, OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NORM, ST_SQ_MUL, ST_SQ_POST, ST_LG_MUL, ST_DB, ST_GC_MUL,
        ST_KNEE_MUL, ST_DIV_INIT, ST_DIV, ST_TGT, ST_SM_MUL, ST_SM, ST_GL_MUL,
        ST_GL, ST_GM_MUL, ST_GM_POST, ST_GSHIFT, ST_WET_MUL, ST_WET,
        ST_MIX_MUL1, ST_MIX_MUL2, ST_OUT
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] step;
    } cmd_t;

    typedef struct packed {
        logic mag_zero;
        logic z_top;
        logic straight;
        logic knee;
        logic out_free;
    } status_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Factor 2^(2^-(k+1)) in Q30, built by chained square roots starting from 2.
    function automatic logic [31:0] fac_q30(input int k);
        logic [63:0] f;
        f = isqrt64(64'd1 << 61);
        for (int j = 1; j < GAIN_STEPS; j++)
        begin
            if (j <= k)
            begin
                f = isqrt64(f << 30);
            end
        end
        return f[31:0];
    endfunction

    localparam logic [31:0] FAC_Q30 [GAIN_STEPS] = '{
        fac_q30(0),  fac_q30(1),  fac_q30(2),  fac_q30(3),
        fac_q30(4),  fac_q30(5),  fac_q30(6),  fac_q30(7),
        fac_q30(8),  fac_q30(9),  fac_q30(10), fac_q30(11),
        fac_q30(12), fac_q30(13), fac_q30(14), fac_q30(15)
    };

    // Shift right with rounding to nearest, halves away from zero.
    function automatic logic signed [WIDE_W-1:0] round_shift(
        input logic signed [WIDE_W-1:0] v,
        input int                       sh
    );
        logic [WIDE_W-1:0] mag;
        logic [WIDE_W-1:0] r;
        mag = v[WIDE_W-1] ? (~v + 68'd1) : v;
        r   = (mag + (68'd1 << (sh - 1))) >> sh;
        return v[WIDE_W-1] ? -$signed(r) : $signed(r);
    endfunction

endpackage

// ===== rtl/core/skng_if.sv =====
// Valid/ready channel interfaces for the gate's sample items and result items.
interface skng_in_if #(
    parameter int SAMPLE_BITS = skng_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] key_sample;

    modport source(output valid, channel, sample, key_sample, input ready);
    modport sink(input valid, channel, sample, key_sample, output ready);
endinterface

interface skng_out_if #(
    parameter int SAMPLE_BITS = skng_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          out_channel;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic signed [16:0]            gain_reduction_db;

    modport source(output valid, out_channel, out_sample, gain_reduction_db, input ready);
    modport sink(input valid, out_channel, out_sample, gain_reduction_db, output ready);
endinterface

// ===== rtl/core/skng_cfg.sv =====
// Configuration register file of the gate.
module skng_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  we,
    input  logic [skng_pkg::CFG_INDEX_W-1:0]      index,
    input  logic [skng_pkg::CFG_DATA_W-1:0]       data,
    output skng_pkg::cfg_t                        cfg
);

    skng_pkg::cfg_t cfg_reg;
    skng_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (we)
        begin
            case (skng_pkg::cfg_index_t'(index))
                skng_pkg::REG_THRESHOLD: cfg_next.threshold = $signed(data[15:0]);
                skng_pkg::REG_KNEE:      cfg_next.knee      = data[13:0];
                skng_pkg::REG_SLOPE:     cfg_next.slope     = data[14:0];
                skng_pkg::REG_ATTACK:    cfg_next.attack    = data[15:0];
                skng_pkg::REG_RELEASE:   cfg_next.release_c = data[15:0];
                // A mix beyond full scale behaves as fully processed.
                skng_pkg::REG_MIX:
                    cfg_next.mix = (data > skng_pkg::MIX_FULL) ? skng_pkg::MIX_FULL : data;
                skng_pkg::REG_USE_KEY:   cfg_next.use_key   = data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= skng_pkg::THRESHOLD_RST;
            cfg_reg.knee      <= skng_pkg::KNEE_RST;
            cfg_reg.slope     <= skng_pkg::SLOPE_RST;
            cfg_reg.attack    <= skng_pkg::ATTACK_RST;
            cfg_reg.release_c <= skng_pkg::RELEASE_RST;
            cfg_reg.mix       <= skng_pkg::MIX_FULL;
            cfg_reg.use_key   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/skng_ctrl.sv =====
// Sequencing state machine of the gate: steps the datapath through one item.
module skng_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  skng_pkg::status_t  status,
    output skng_pkg::cmd_t     cmd
);

    skng_pkg::state_t              state_reg;
    skng_pkg::state_t              state_next;
    logic [skng_pkg::CNT_W-1:0]    cnt_reg;
    logic [skng_pkg::CNT_W-1:0]    cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skng_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = skng_pkg::OP_NONE;
        cmd.step   = cnt_reg[3:0];
        case (state_reg)
            skng_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = skng_pkg::OP_LOAD;
                    state_next = skng_pkg::ST_NORM;
                end
            end
            skng_pkg::ST_NORM:
            begin
                cnt_next = '0;
                if (status.mag_zero)
                begin
                    state_next = skng_pkg::ST_DB;
                end
                else if (status.z_top)
                begin
                    state_next = skng_pkg::ST_SQ_MUL;
                end
                else
                begin
                    cmd.op = skng_pkg::OP_NORM;
                end
            end
            skng_pkg::ST_SQ_MUL:
            begin
                cmd.op     = skng_pkg::OP_SQ_MUL;
                state_next = skng_pkg::ST_SQ_POST;
            end
            skng_pkg::ST_SQ_POST:
            begin
                cmd.op   = skng_pkg::OP_SQ_POST;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(skng_pkg::SQ_STEPS - 1))
                begin
                    state_next = skng_pkg::ST_LG_MUL;
                end
                else
                begin
                    state_next = skng_pkg::ST_SQ_MUL;
                end
            end
            skng_pkg::ST_LG_MUL:
            begin
                cmd.op     = skng_pkg::OP_LG_MUL;
                state_next = skng_pkg::ST_DB;
            end
            skng_pkg::ST_DB:
            begin
                cmd.op     = skng_pkg::OP_DB;
                state_next = skng_pkg::ST_GC_MUL;
            end
            skng_pkg::ST_GC_MUL:
            begin
                cmd.op     = skng_pkg::OP_GC_MUL;
                state_next = status.knee ? skng_pkg::ST_KNEE_MUL : skng_pkg::ST_TGT;
            end
            skng_pkg::ST_KNEE_MUL:
            begin
                cmd.op     = skng_pkg::OP_KNEE_MUL;
                state_next = skng_pkg::ST_DIV_INIT;
            end
            skng_pkg::ST_DIV_INIT:
            begin
                cmd.op     = skng_pkg::OP_DIV_INIT;
                cnt_next   = '0;
                state_next = skng_pkg::ST_DIV;
            end
            skng_pkg::ST_DIV:
            begin
                cmd.op   = skng_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(skng_pkg::DIV_STEPS - 1))
                begin
                    state_next = skng_pkg::ST_TGT;
                end
            end
            skng_pkg::ST_TGT:
            begin
                cmd.op     = skng_pkg::OP_TGT;
                state_next = skng_pkg::ST_SM_MUL;
            end
            skng_pkg::ST_SM_MUL:
            begin
                cmd.op     = skng_pkg::OP_SM_MUL;
                state_next = skng_pkg::ST_SM;
            end
            skng_pkg::ST_SM:
            begin
                cmd.op     = skng_pkg::OP_SM;
                state_next = skng_pkg::ST_GL_MUL;
            end
            skng_pkg::ST_GL_MUL:
            begin
                cmd.op     = skng_pkg::OP_GL_MUL;
                state_next = skng_pkg::ST_GL;
            end
            skng_pkg::ST_GL:
            begin
                cmd.op     = skng_pkg::OP_GL;
                cnt_next   = '0;
                state_next = skng_pkg::ST_GM_MUL;
            end
            skng_pkg::ST_GM_MUL:
            begin
                cmd.op     = skng_pkg::OP_GM_MUL;
                state_next = skng_pkg::ST_GM_POST;
            end
            skng_pkg::ST_GM_POST:
            begin
                cmd.op   = skng_pkg::OP_GM_POST;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(skng_pkg::GAIN_STEPS - 1))
                begin
                    state_next = skng_pkg::ST_GSHIFT;
                end
                else
                begin
                    state_next = skng_pkg::ST_GM_MUL;
                end
            end
            skng_pkg::ST_GSHIFT:
            begin
                cmd.op     = skng_pkg::OP_GSHIFT;
                state_next = skng_pkg::ST_WET_MUL;
            end
            skng_pkg::ST_WET_MUL:
            begin
                cmd.op     = skng_pkg::OP_WET_MUL;
                state_next = skng_pkg::ST_WET;
            end
            skng_pkg::ST_WET:
            begin
                cmd.op     = skng_pkg::OP_WET;
                state_next = skng_pkg::ST_MIX_MUL1;
            end
            skng_pkg::ST_MIX_MUL1:
            begin
                cmd.op     = skng_pkg::OP_MIX_MUL1;
                state_next = skng_pkg::ST_MIX_MUL2;
            end
            skng_pkg::ST_MIX_MUL2:
            begin
                cmd.op     = skng_pkg::OP_MIX_MUL2;
                state_next = skng_pkg::ST_OUT;
            end
            skng_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = skng_pkg::OP_OUT;
                    state_next = skng_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skng_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/skng_dp.sv =====
// Datapath of the gate: level detector, gain computer, smoothing, gain and mix
// around one shared multiplier.
module skng_dp #(
    parameter int CHANNELS    = skng_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = skng_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  skng_pkg::cmd_t                cmd,
    output skng_pkg::status_t             status,
    input  skng_pkg::cfg_t                cfg,
    input  logic                          in_channel,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic signed [SAMPLE_BITS-1:0] in_key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_channel,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    output logic signed [16:0]            out_reduction
);

    localparam int MW = skng_pkg::MUL_W;
    localparam int PW = skng_pkg::PROD_W;
    localparam int WW = skng_pkg::WIDE_W;
    localparam int RW = skng_pkg::RED_W;
    localparam int DW = skng_pkg::DIV_W;

    // Per-channel smoothed reduction.
    logic signed [RW-1:0] red_reg [2];
    logic                 out_valid_reg;

    logic                          ch_reg;
    logic signed [31:0]            x_reg;
    logic signed [RW-1:0]          cur_reg;
    logic [31:0]                   z_reg;
    logic [4:0]                    e_reg;
    logic [15:0]                   frac_reg;
    logic                          mzero_reg;
    logic signed [RW-1:0]          lvl_reg;
    logic signed [PW-1:0]          p_reg;
    logic signed [PW-1:0]          acc_reg;
    logic [13:0]                   rem_reg;
    logic [DW-1:0]                 quo_reg;
    logic signed [RW-1:0]          tgt_reg;
    logic signed [RW-1:0]          y_reg;
    logic [31:0]                   g_reg;
    logic [15:0]                   f_reg;
    logic [5:0]                    ip_reg;
    logic                          gzero_reg;
    logic signed [31:0]            wet_reg;
    logic signed [SAMPLE_BITS-1:0] osample_reg;
    logic                          och_reg;
    logic signed [16:0]            ored_reg;

    logic                 slot;
    logic                 load_slot;
    logic signed [32:0]   det;
    logic [31:0]          mag;
    logic signed [6:0]    e_off;
    logic signed [22:0]   lg_val;
    logic signed [19:0]   d2;
    logic signed [19:0]   t2;
    logic signed [19:0]   kw;
    logic signed [19:0]   k0;
    logic signed [19:0]   k1;
    logic signed [19:0]   x2;
    logic                 straight;
    logic                 knee_r;
    logic [15:0]          coeff;
    logic [31:0]          zz;
    logic [14:0]          rem_sh;
    logic [DW:0]          nsum;
    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [WW-1:0] db_w;
    logic signed [WW-1:0] tgt_w;
    logic signed [WW-1:0] y_w;
    logic signed [WW-1:0] lg2_w;
    logic signed [WW-1:0] o_w;
    logic [21:0]          negv;
    logic [PW-1:0]        g_round;

    assign slot      = (CHANNELS == 1) ? 1'b0 : ch_reg;
    assign load_slot = (CHANNELS == 1) ? 1'b0 : in_channel;

    assign det = cfg.use_key ? 33'(in_key) : 33'(in_sample);
    assign mag = 32'(det[32] ? -det : det);

    assign e_off  = $signed({2'b00, e_reg}) - 7'(SAMPLE_BITS - 1);
    assign lg_val = $signed({e_off, frac_reg});

    assign d2       = 20'(lvl_reg) + 20'(lvl_reg);
    assign t2       = 20'(cfg.threshold) + 20'(cfg.threshold);
    assign kw       = $signed({6'd0, cfg.knee});
    assign k0       = t2 - kw;
    assign k1       = t2 + kw;
    assign x2       = d2 - k1;
    assign straight = d2 < k0;
    assign knee_r   = !straight && (d2 < k1);

    assign coeff = (tgt_reg < cur_reg) ? cfg.attack : cfg.release_c;
    assign zz    = p_reg[61:30];

    // Knee division: round(num / (W*2048)) as floor((num + W*1024) >> 11) / W.
    assign nsum   = (DW + 1)'(($unsigned(p_reg) + (66'(cfg.knee) << 10)) >> 11);
    assign rem_sh = {rem_reg, quo_reg[DW-1]};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            skng_pkg::OP_SQ_MUL:
            begin
                mul_a = $signed({1'b0, z_reg});
                mul_b = $signed({1'b0, z_reg});
            end
            skng_pkg::OP_LG_MUL:
            begin
                mul_a = 33'(lg_val);
                mul_b = skng_pkg::DB_PER_OCT_Q16;
            end
            skng_pkg::OP_GC_MUL:
            begin
                if (straight)
                begin
                    mul_a = 33'(lvl_reg) - 33'(cfg.threshold);
                    mul_b = $signed({18'd0, cfg.slope});
                end
                else
                begin
                    mul_a = 33'(x2);
                    mul_b = 33'(x2);
                end
            end
            skng_pkg::OP_KNEE_MUL:
            begin
                mul_a = $signed({3'd0, p_reg[29:0]});
                mul_b = $signed({18'd0, cfg.slope});
            end
            skng_pkg::OP_SM_MUL:
            begin
                mul_a = $signed(33'(skng_pkg::MIX_FULL - {1'b0, coeff}));
                mul_b = 33'(tgt_reg) - 33'(cur_reg);
            end
            skng_pkg::OP_GL_MUL:
            begin
                mul_a = 33'(y_reg);
                mul_b = skng_pkg::OCT_PER_DB_Q24;
            end
            skng_pkg::OP_GM_MUL:
            begin
                // A clear fraction bit multiplies by unity, which leaves the gain as it is.
                mul_a = $signed({1'b0, g_reg});
                mul_b = f_reg[~cmd.step] ? $signed({1'b0, skng_pkg::FAC_Q30[cmd.step]})
                                         : skng_pkg::UNITY_Q30;
            end
            skng_pkg::OP_WET_MUL:
            begin
                mul_a = 33'(x_reg);
                mul_b = $signed({1'b0, g_reg});
            end
            skng_pkg::OP_MIX_MUL1:
            begin
                mul_a = 33'(wet_reg);
                mul_b = $signed(33'(cfg.mix));
            end
            skng_pkg::OP_MIX_MUL2:
            begin
                mul_a = 33'(x_reg);
                mul_b = $signed(33'(skng_pkg::MIX_FULL - cfg.mix));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign db_w  = skng_pkg::round_shift(68'(p_reg), 24);
    assign tgt_w = straight ? skng_pkg::round_shift(68'(p_reg), 8)
                 : (knee_r ? -$signed(68'(quo_reg)) : 68'sd0);
    assign y_w   = 68'(cur_reg) + skng_pkg::round_shift(68'(p_reg), 16);
    assign lg2_w = skng_pkg::round_shift(68'(p_reg), 16);
    assign negv  = 22'(-lg2_w);
    assign o_w   = skng_pkg::round_shift(68'(acc_reg) + 68'(p_reg), 16);
    assign g_round = $unsigned(p_reg) + (66'd1 << 29);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg[0]    <= '0;
            red_reg[1]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == skng_pkg::OP_SM)
            begin
                red_reg[slot] <= (y_w < 68'(skng_pkg::RED_FLOOR)) ? skng_pkg::RED_FLOOR
                               : ((y_w > 68'sd0) ? 18'sd0 : RW'(y_w));
            end
            if (cmd.op == skng_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            skng_pkg::OP_LOAD:
            begin
                ch_reg    <= in_channel;
                x_reg     <= 32'(in_sample);
                cur_reg   <= red_reg[load_slot];
                mzero_reg <= (mag == 32'd0);
                frac_reg  <= '0;
                if (mag[31])
                begin
                    z_reg <= mag >> 1;
                    e_reg <= 5'd31;
                end
                else
                begin
                    z_reg <= mag;
                    e_reg <= 5'd30;
                end
            end
            skng_pkg::OP_NORM:
            begin
                z_reg <= z_reg << 1;
                e_reg <= e_reg - 5'd1;
            end
            skng_pkg::OP_SQ_POST:
            begin
                if (zz[31])
                begin
                    z_reg    <= zz >> 1;
                    frac_reg <= {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    z_reg    <= zz;
                    frac_reg <= {frac_reg[14:0], 1'b0};
                end
            end
            skng_pkg::OP_DB:
            begin
                if (mzero_reg || (db_w < 68'(skng_pkg::DB_FLOOR)))
                begin
                    lvl_reg <= skng_pkg::DB_FLOOR;
                end
                else
                begin
                    lvl_reg <= RW'(db_w);
                end
            end
            skng_pkg::OP_DIV_INIT:
            begin
                rem_reg <= '0;
                quo_reg <= nsum[DW-1:0];
            end
            skng_pkg::OP_DIV_STEP:
            begin
                if (rem_sh >= {1'b0, cfg.knee})
                begin
                    rem_reg <= 14'(rem_sh - {1'b0, cfg.knee});
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[13:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
            end
            skng_pkg::OP_TGT:
            begin
                tgt_reg <= (tgt_w < 68'(skng_pkg::RED_FLOOR)) ? skng_pkg::RED_FLOOR
                         : ((tgt_w > 68'sd0) ? 18'sd0 : RW'(tgt_w));
            end
            skng_pkg::OP_SM:
            begin
                y_reg <= (y_w < 68'(skng_pkg::RED_FLOOR)) ? skng_pkg::RED_FLOOR
                       : ((y_w > 68'sd0) ? 18'sd0 : RW'(y_w));
            end
            skng_pkg::OP_GL:
            begin
                // Round the octave count up so the factors only ever raise the gain.
                gzero_reg <= (y_reg <= skng_pkg::DB_FLOOR);
                g_reg     <= 32'd1 << 30;
                if (negv[15:0] != 16'd0)
                begin
                    ip_reg <= negv[21:16] + 6'd1;
                    f_reg  <= ~negv[15:0] + 16'd1;
                end
                else
                begin
                    ip_reg <= negv[21:16];
                    f_reg  <= '0;
                end
            end
            skng_pkg::OP_GM_POST:
            begin
                g_reg <= g_round[61:30];
            end
            skng_pkg::OP_GSHIFT:
            begin
                g_reg <= (gzero_reg || ip_reg[5]) ? 32'd0 : (g_reg >> ip_reg[4:0]);
            end
            skng_pkg::OP_WET:
            begin
                wet_reg <= 32'(skng_pkg::round_shift(68'(p_reg), 30));
            end
            skng_pkg::OP_MIX_MUL2:
            begin
                acc_reg <= p_reg;
            end
            skng_pkg::OP_OUT:
            begin
                och_reg     <= ch_reg;
                osample_reg <= SAMPLE_BITS'(o_w);
                ored_reg    <= y_reg[16:0];
            end
            default:
            begin
            end
        endcase

        case (cmd.op)
            skng_pkg::OP_SQ_MUL, skng_pkg::OP_LG_MUL, skng_pkg::OP_GC_MUL,
            skng_pkg::OP_KNEE_MUL, skng_pkg::OP_SM_MUL, skng_pkg::OP_GL_MUL,
            skng_pkg::OP_GM_MUL, skng_pkg::OP_WET_MUL, skng_pkg::OP_MIX_MUL1,
            skng_pkg::OP_MIX_MUL2:
            begin
                p_reg <= prod;
            end
            default:
            begin
            end
        endcase
    end

    assign status.mag_zero = mzero_reg;
    assign status.z_top    = z_reg[30];
    assign status.straight = straight;
    assign status.knee     = knee_r;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign out_channel   = och_reg;
    assign out_sample    = osample_reg;
    assign out_reduction = ored_reg;

endmodule

// ===== rtl/core/soft_knee_noise_gate_unit.sv =====
// Top level of the soft-knee noise gate: configuration, sequencer and datapath.
//
//  Port     Role          Carries
//  audio    item in       channel, sample, key_sample
//  result   item out      out_channel, out_sample, gain_reduction_db
//  cfg_*    write port    cfg_we, cfg_index, cfg_data
//
// Silence skips the detector; otherwise the level normalisation shifts one bit a cycle
// and sixteen squarings follow. Sixteen gain factors are always applied, and a level
// inside the soft knee adds a 34-step division. All share one 33 by 33 multiplier.
// Reset clears the configuration to its defaults and every channel's reduction to 0 dB.
// A new item is taken while the previous result waits in the output register; the
// sequencer only holds at its last step when that register is still full.
module soft_knee_noise_gate_unit #(
    parameter int CHANNELS    = skng_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = skng_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    skng_in_if.sink                            audio,
    skng_out_if.source                         result,
    input  logic                               cfg_we,
    input  logic [skng_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [skng_pkg::CFG_DATA_W-1:0]    cfg_data
);

    skng_pkg::cfg_t    cfg;
    skng_pkg::cmd_t    cmd;
    skng_pkg::status_t status;

    skng_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    skng_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (audio.valid),
        .in_ready (audio.ready),
        .status   (status),
        .cmd      (cmd)
    );

    skng_dp #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg),
        .in_channel    (audio.channel),
        .in_sample     (audio.sample),
        .in_key        (audio.key_sample),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_channel   (result.out_channel),
        .out_sample    (result.out_sample),
        .out_reduction (result.gain_reduction_db)
    );

endmodule

// ===== tb/sv/soft_knee_noise_gate_unit_test.sv =====
// Self-checking bench for the soft-knee noise gate: random items, phased configuration.
module soft_knee_noise_gate_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [skng_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        bit                 channel;
        logic signed [23:0] sample;
        logic signed [23:0] key_sample;
    } audio_item_t;

    typedef struct {
        bit                 channel;
        logic [23:0]        sample;
        logic [16:0]        reduction;
    } gated_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [skng_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [skng_pkg::CFG_DATA_W-1:0]  cfg_data;

    skng_in_if  #(.SAMPLE_BITS(24)) audio();
    skng_out_if #(.SAMPLE_BITS(24)) result();

    soft_knee_noise_gate_unit #(.CHANNELS(2), .SAMPLE_BITS(24)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .audio(audio.sink),
        .result(result.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    audio_item_t pending_audio[$];
    gated_item_t expected_gated[$];
    int          mismatches;
    bit          calm;
    int          in_gap;
    int          out_gap;

    // Mirror of the gate's settings and per-channel smoothed reduction.
    longint      gate_threshold, gate_knee, gate_slope, gate_attack, gate_release, gate_mix;
    bit          gate_use_key;
    longint      held_reduction[2];
    longint unsigned octave_root_q30[16];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint half_up_shift(longint v, int sh);
        longint unsigned mag;
        longint unsigned r;
        mag = (v < 0) ? longint'(-v) : v;
        r = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip_reduction(longint v);
        if (v < -65280)
            return -65280;
        if (v > 0)
            return 0;
        return v;
    endfunction

    function automatic longint level_in_db(longint x);
        longint unsigned m;
        longint unsigned z;
        longint unsigned frac;
        longint lg;
        longint db;
        int e;
        m = (x < 0) ? -x : x;
        e = 0;
        frac = 0;
        if (m == 0)
            return -25600;
        while ((m >> (e + 1)) != 0)
            e++;
        z = m << (30 - e);
        for (int i = 0; i < 16; i++)
        begin
            z = (z * z) >> 30;
            frac = frac << 1;
            if (z >= (64'd1 << 31))
            begin
                z = z >> 1;
                frac = frac | 1;
            end
        end
        lg = longint'(e - 23) * 65536 + longint'(frac);
        db = half_up_shift(lg * 394566, 24);
        return (db < -25600) ? -25600 : db;
    endfunction

    function automatic longint knee_target(longint d);
        longint d2;
        longint k0;
        longint k1;
        longint t;
        longint x2;
        longint unsigned num;
        longint unsigned den;
        d2 = 2 * d;
        k0 = 2 * gate_threshold - gate_knee;
        k1 = 2 * gate_threshold + gate_knee;
        t = 0;
        if (d2 < k0)
            t = half_up_shift((d - gate_threshold) * gate_slope, 8);
        else if (d2 < k1)
        begin
            x2 = d2 - k1;
            num = longint'(gate_slope) * (x2 * x2);
            den = longint'(gate_knee) * 2048;
            t = -longint'((num + den / 2) / den);
        end
        return clip_reduction(t);
    endfunction

    function automatic longint unsigned linear_gain_q30(longint red);
        longint unsigned g;
        longint unsigned neg;
        longint unsigned ip;
        longint unsigned fr;
        longint unsigned f;
        longint lg;
        g = 64'd1 << 30;
        if (red <= -25600)
            return 0;
        lg = half_up_shift(red * 2786635, 16);
        if (lg >= 0)
            return g;
        neg = -lg;
        ip = neg >> 16;
        fr = neg & 16'hFFFF;
        f = 0;
        if (fr != 0)
        begin
            ip++;
            f = 65536 - fr;
        end
        for (int i = 0; i < 16; i++)
            if ((f >> (15 - i)) & 1)
                g = (g * octave_root_q30[i] + (64'd1 << 29)) >> 30;
        if (ip >= 32)
            return 0;
        return g >> ip;
    endfunction

    function automatic gated_item_t gate_sample(audio_item_t it);
        gated_item_t r;
        longint x;
        longint cur;
        longint tgt;
        longint coeff;
        longint y;
        longint wet;
        longint o;
        x = it.sample;
        cur = held_reduction[it.channel];
        tgt = knee_target(level_in_db(gate_use_key ? longint'(it.key_sample) : x));
        coeff = (tgt < cur) ? gate_attack : gate_release;
        y = clip_reduction(cur + half_up_shift((65536 - coeff) * (tgt - cur), 16));
        wet = half_up_shift(x * longint'(linear_gain_q30(y)), 30);
        o = half_up_shift(wet * gate_mix + x * (65536 - gate_mix), 16);
        held_reduction[it.channel] = y;
        r.channel = it.channel;
        r.sample = o[23:0];
        r.reduction = y[16:0];
        return r;
    endfunction

    // Sender: items leave the queue one at a time, with short random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            audio.valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (audio.valid && audio.ready)
                expected_gated.push_back(gate_sample('{audio.channel, audio.sample,
                                                       audio.key_sample}));
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                audio.valid <= 1'b0;
            end
            else if (!audio.valid || audio.ready)
            begin
                if (pending_audio.size() == 0)
                    audio.valid <= 1'b0;
                else if (!calm && $urandom_range(0, 7) == 0)
                begin
                    in_gap <= $urandom_range(0, 2);
                    audio.valid <= 1'b0;
                end
                else
                begin
                    audio_item_t it;
                    it = pending_audio.pop_front();
                    audio.channel <= it.channel;
                    audio.sample <= it.sample;
                    audio.key_sample <= it.key_sample;
                    audio.valid <= 1'b1;
                end
            end
        end
    end

    // Receiver: stalls in bursts and checks every item against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_gated.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item ch=%0d out=%0d red=%0d",
                                 result.out_channel, result.out_sample,
                                 result.gain_reduction_db);
                end
                else
                begin
                    gated_item_t e;
                    e = expected_gated.pop_front();
                    if (e.channel !== result.out_channel || e.sample !== result.out_sample
                        || e.reduction !== result.gain_reduction_db)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected ch=%0d out=%0d red=%0d, ",
                                      "got ch=%0d out=%0d red=%0d"},
                                     e.channel, $signed(e.sample), $signed(e.reduction),
                                     result.out_channel, result.out_sample,
                                     result.gain_reduction_db);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                result.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(0, 2);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [skng_pkg::CFG_INDEX_W-1:0] idx,
                             logic [skng_pkg::CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            skng_pkg::REG_THRESHOLD: gate_threshold = longint'($signed(d[15:0]));
            skng_pkg::REG_KNEE:      gate_knee = d[13:0];
            skng_pkg::REG_SLOPE:     gate_slope = d[14:0];
            skng_pkg::REG_ATTACK:    gate_attack = d[15:0];
            skng_pkg::REG_RELEASE:   gate_release = d[15:0];
            skng_pkg::REG_MIX:       gate_mix = (d > skng_pkg::MIX_FULL) ? 65536 : d;
            skng_pkg::REG_USE_KEY:   gate_use_key = d[0];
            default:       ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge clk);
        #1;
        while (pending_audio.size() != 0 || expected_gated.size() != 0 || audio.valid)
        begin
            @(posedge clk);
            #1;
        end
        repeat (8) @(posedge clk);
    endtask

    // Levels spread over the whole dB range, with the full-scale extremes now and then.
    function automatic logic signed [23:0] any_level();
        logic signed [23:0] v;
        case ($urandom_range(0, 15))
            0: v = 24'sh7FFFFF;
            1: v = 24'sh800000;
            2: v = 24'sd0;
            default:
            begin
                v = 24'($urandom);
                v = v >>> $urandom_range(0, 23);
            end
        endcase
        return v;
    endfunction

    task automatic queue_item(bit ch, logic signed [23:0] s, logic signed [23:0] k);
        pending_audio.push_back('{ch, s, k});
    endtask

    task automatic random_run(int n);
        for (int i = 0; i < n; i++)
        begin
            // Runs of one loudness class drive the smoother through attack and release.
            if ($urandom_range(0, 3) == 0)
            begin
                logic signed [23:0] base;
                base = any_level();
                for (int j = 0; j < 6; j++)
                    queue_item(1'($urandom_range(0, 1)), base ^ 24'($urandom_range(0, 255)),
                               any_level());
                i += 5;
            end
            else
                queue_item(1'($urandom_range(0, 1)), any_level(), any_level());
        end
    endtask

    task automatic random_settings();
        logic [16:0] mixes[4];
        mixes = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768};
        write_reg(skng_pkg::REG_THRESHOLD, ($urandom_range(0, 3) == 0) ?
                  (($urandom_range(0, 1) != 0) ? 17'h08000 : 17'd0) :
                  17'(-$urandom_range(0, 32768)));
        write_reg(skng_pkg::REG_KNEE, ($urandom_range(0, 3) == 0) ? 17'd0 :
                  17'($urandom_range(0, 12288)));
        write_reg(skng_pkg::REG_SLOPE, ($urandom_range(0, 3) == 0) ? 17'd25344 :
                  17'($urandom_range(0, 25344)));
        write_reg(skng_pkg::REG_ATTACK, ($urandom_range(0, 2) == 0) ?
                  17'($urandom_range(0, 1) * 65535) : 17'($urandom_range(0, 65535)));
        write_reg(skng_pkg::REG_RELEASE, ($urandom_range(0, 2) == 0) ?
                  17'($urandom_range(0, 1) * 65535) : 17'($urandom_range(0, 65535)));
        write_reg(skng_pkg::REG_MIX, ($urandom_range(0, 1) != 0) ?
                  mixes[$urandom_range(0, 3)] : 17'($urandom));
        write_reg(skng_pkg::REG_USE_KEY, 17'($urandom_range(0, 1)));
        write_reg(REG_SPARE, 17'($urandom));
        end_writes();
    endtask

    initial
    begin
        longint unsigned f;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        mismatches = 0;
        audio.valid = 1'b0;
        audio.channel = 1'b0;
        audio.sample = '0;
        audio.key_sample = '0;
        result.ready = 1'b0;
        f = int_sqrt(64'd1 << 61);
        octave_root_q30[0] = f;
        for (int i = 1; i < 16; i++)
            octave_root_q30[i] = int_sqrt(octave_root_q30[i - 1] << 30);
        gate_threshold = -10240;
        gate_knee = 0;
        gate_slope = 256;
        gate_attack = 65400;
        gate_release = 65400;
        gate_mix = 65536;
        gate_use_key = 1'b0;
        held_reduction[0] = 0;
        held_reduction[1] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults: full-scale extremes, silence and a faint level on both channels.
        queue_item(1'b0, 24'sh7FFFFF, 24'sd0);
        queue_item(1'b1, 24'sh800000, 24'sd0);
        queue_item(1'b0, 24'sd0, 24'sh7FFFFF);
        queue_item(1'b1, 24'sd1, 24'sh800000);
        queue_item(1'b0, -24'sd1, 24'sd1);
        queue_item(1'b1, 24'sd100, 24'sd0);
        queue_item(1'b0, 24'sd4000, 24'sd0);
        wait_drained();

        // Key detection with a hard knee, instant attack and half mix.
        write_reg(skng_pkg::REG_USE_KEY, 17'd1);
        write_reg(skng_pkg::REG_ATTACK, 17'd0);
        write_reg(skng_pkg::REG_RELEASE, 17'd65535);
        write_reg(skng_pkg::REG_MIX, 17'd32768);
        write_reg(skng_pkg::REG_SLOPE, 17'd25344);
        end_writes();
        queue_item(1'b0, 24'sh7FFFFF, 24'sd0);
        queue_item(1'b1, 24'sh800000, 24'sd3);
        queue_item(1'b0, 24'sh400000, 24'sh7FFFFF);
        queue_item(1'b1, 24'sh123456, 24'sh800000);
        wait_drained();

        // Widest soft knee at the top threshold, mix above full, spare index ignored.
        write_reg(skng_pkg::REG_THRESHOLD, 17'd0);
        write_reg(skng_pkg::REG_KNEE, 17'd12288);
        write_reg(skng_pkg::REG_MIX, 17'h1FFFF);
        write_reg(skng_pkg::REG_RELEASE, 17'd0);
        write_reg(skng_pkg::REG_USE_KEY, 17'd0);
        write_reg(REG_SPARE, 17'h1FFFF);
        end_writes();
        for (int i = 0; i < 8; i++)
            queue_item(i[0], 24'sh7FFFFF >>> (3 * i), 24'sd0);
        wait_drained();

        // Lowest threshold, no slope, dry output only.
        write_reg(skng_pkg::REG_THRESHOLD, 17'h08000);
        write_reg(skng_pkg::REG_SLOPE, 17'd0);
        write_reg(skng_pkg::REG_MIX, 17'd0);
        end_writes();
        queue_item(1'b0, 24'sd5, 24'sd0);
        queue_item(1'b1, 24'sh800000, 24'sd0);
        wait_drained();

        for (int p = 0; p < 9; p++)
        begin
            random_settings();
            if (p == 8)
                calm = 1'b1;
            random_run(200);
            wait_drained();
        end
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_gated.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== soft_knee_noise_gate_unit.f =====
rtl/core/skng_pkg.sv
rtl/core/skng_if.sv
rtl/core/skng_cfg.sv
rtl/core/skng_ctrl.sv
rtl/core/skng_dp.sv
rtl/core/soft_knee_noise_gate_unit.sv
tb/sv/soft_knee_noise_gate_unit_test.sv
